// ----- design/esfs_pkg.sv -----
`timescale 1ns / 1ps

package esfs_pkg;

	localparam int NEEDLE_MAX = 16;
	localparam int BYTE_W     = 8;
	localparam int REG_W      = 64;
	localparam int LEN_W      = 5;
	localparam int IDX_W      = 2;
	localparam int KIND_W     = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_NEEDLE_LOW  = 2'd0,
		REG_NEEDLE_HIGH = 2'd1,
		REG_NEEDLE_LEN  = 2'd2
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE   = 2'd0,
		KIND_EXACT  = 2'd1,
		KIND_FOLDED = 2'd2
	} match_kind_t;

	// Broadcast to every cell of the chain in the same cycle.
	typedef struct packed {
		logic              advance;
		logic              clear;
		logic [BYTE_W-1:0] text_byte;
		logic [BYTE_W-1:0] folded_byte;
	} cell_ctrl_t;

	function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

// ----- design/esfs_if.sv -----
`timescale 1ns / 1ps

interface esfs_in_if;
	logic                        valid;
	logic                        ready;
	logic [esfs_pkg::BYTE_W-1:0] text_byte;
	logic                        is_final;
	logic                        carries_nothing;

	modport source (output valid, output text_byte, output is_final,
		output carries_nothing, input ready);
	modport sink (input valid, input text_byte, input is_final,
		input carries_nothing, output ready);
endinterface

interface esfs_out_if;
	logic                        valid;
	logic                        ready;
	logic [esfs_pkg::KIND_W-1:0] match_kind;

	modport source (output valid, output match_kind, input ready);
	modport sink (input valid, input match_kind, output ready);
endinterface

// ----- design/esfs_cell.sv -----
`timescale 1ns / 1ps

module esfs_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  esfs_pkg::cell_ctrl_t        ctrl,
	input  logic [esfs_pkg::BYTE_W-1:0] needle_byte,
	input  logic                        in_use,
	input  logic                        is_last,
	input  logic                        prev_exact,
	input  logic                        prev_folded,
	output logic                        exact,
	output logic                        folded,
	output logic                        exact_hit,
	output logic                        folded_hit
);

	logic exact_q;
	logic folded_q;
	logic exact_nxt;
	logic folded_nxt;

	// Extend the neighbor's partial match by one byte.
	assign exact_nxt  = prev_exact & in_use & (needle_byte == ctrl.text_byte);
	assign folded_nxt = prev_folded & in_use &
		(esfs_pkg::fold_byte(needle_byte) == ctrl.folded_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_q  <= 1'b0;
			folded_q <= 1'b0;
		end else if (ctrl.clear) begin
			exact_q  <= 1'b0;
			folded_q <= 1'b0;
		end else if (ctrl.advance) begin
			exact_q  <= exact_nxt;
			folded_q <= folded_nxt;
		end
	end

	assign exact      = exact_q;
	assign folded     = folded_q;
	assign exact_hit  = exact_nxt & is_last;
	assign folded_hit = folded_nxt & is_last;

endmodule

// ----- design/exact_and_folded_substring_search_unit.sv -----
`timescale 1ns / 1ps

// Streaming substring search, exact and ASCII case-folded.
// Haystack bytes come in on in_ch, one request per byte; is_final marks the
// last request of a haystack and carries_nothing a request with no byte
// (used to end an empty haystack). On every final request one result leaves
// on out_ch: match_kind 1 for an exact hit, 2 for a hit only after folding
// A-Z to lower case, 0 for none. An empty needle always gives 1.
// The needle (up to 16 bytes) and its length must be written through the
// cfg_we / cfg_index / cfg_data port only while no haystack is in flight;
// the block does not enforce this. Lengths above 16 act as 16.
// Throughput is one byte per cycle while in_ch.ready is high: a row of 16 cells,
// one per needle byte, each holds a partial-match bit and passes it on per byte.
// The result is registered, in the skid entry while the output register is full.
// A two-entry output stage lets input continue while a result waits; input
// stalls whenever both entries are full, even with the receiver's ready high.
// Reset clears the needle registers, all match progress and the output.

module exact_and_folded_substring_search_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	esfs_in_if.sink                     in_ch,
	esfs_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [esfs_pkg::IDX_W-1:0]  cfg_index,
	input  logic [esfs_pkg::REG_W-1:0]  cfg_data
);

	localparam int NM = esfs_pkg::NEEDLE_MAX;
	localparam int LW = esfs_pkg::LEN_W;

	logic [esfs_pkg::REG_W-1:0] needle_low_q;
	logic [esfs_pkg::REG_W-1:0] needle_high_q;
	logic [LW-1:0]              needle_len_q;
	logic [LW-1:0]              len_act;
	logic [2*esfs_pkg::REG_W-1:0] needle_all;

	logic                 in_acc;
	logic                 advance;
	esfs_pkg::cell_ctrl_t ctrl;

	logic [NM-1:0] exact_vec;
	logic [NM-1:0] folded_vec;
	logic [NM-1:0] exact_hits;
	logic [NM-1:0] folded_hits;
	logic [NM-1:0] use_mask;
	logic [NM-1:0] last_mask;

	logic seen_exact_q;
	logic seen_folded_q;
	logic exact_now;
	logic folded_now;
	esfs_pkg::match_kind_t kind_new;

	logic                  out_valid_q;
	esfs_pkg::match_kind_t out_kind_q;
	logic                  skid_valid_q;
	esfs_pkg::match_kind_t skid_kind_q;
	logic                  push;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q  <= '0;
			needle_high_q <= '0;
			needle_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				esfs_pkg::REG_NEEDLE_LOW:  needle_low_q  <= cfg_data;
				esfs_pkg::REG_NEEDLE_HIGH: needle_high_q <= cfg_data;
				esfs_pkg::REG_NEEDLE_LEN:  needle_len_q  <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	assign len_act = (needle_len_q > LW'(NM)) ? LW'(NM) : needle_len_q;
	assign needle_all = {needle_high_q, needle_low_q};

	assign in_ch.ready = !skid_valid_q;
	assign in_acc      = in_ch.valid & in_ch.ready;
	assign advance     = in_acc & !in_ch.carries_nothing & (len_act != '0);

	assign ctrl.advance     = advance;
	assign ctrl.clear       = in_acc & in_ch.is_final;
	assign ctrl.text_byte   = in_ch.text_byte;
	assign ctrl.folded_byte = esfs_pkg::fold_byte(in_ch.text_byte);

	for (genvar k = 0; k < NM; k++) begin : g_cell
		logic prev_e;
		logic prev_f;

		assign use_mask[k]  = LW'(k) < len_act;
		assign last_mask[k] = LW'(k + 1) == len_act;

		if (k == 0) begin : g_head
			assign prev_e = 1'b1;
			assign prev_f = 1'b1;
		end else begin : g_link
			assign prev_e = exact_vec[k-1];
			assign prev_f = folded_vec[k-1];
		end

		esfs_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.needle_byte (needle_all[k*esfs_pkg::BYTE_W +: esfs_pkg::BYTE_W]),
			.in_use      (use_mask[k]),
			.is_last     (last_mask[k]),
			.prev_exact  (prev_e),
			.prev_folded (prev_f),
			.exact       (exact_vec[k]),
			.folded      (folded_vec[k]),
			.exact_hit   (exact_hits[k]),
			.folded_hit  (folded_hits[k])
		);
	end

	assign exact_now  = advance & (|exact_hits);
	assign folded_now = advance & (|folded_hits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_exact_q  <= 1'b0;
			seen_folded_q <= 1'b0;
		end else if (ctrl.clear) begin
			seen_exact_q  <= 1'b0;
			seen_folded_q <= 1'b0;
		end else begin
			seen_exact_q  <= seen_exact_q | exact_now;
			seen_folded_q <= seen_folded_q | folded_now;
		end
	end

	always_comb begin
		priority if ((len_act == '0) || seen_exact_q || exact_now) begin
			kind_new = esfs_pkg::KIND_EXACT;
		end else if (seen_folded_q || folded_now) begin
			kind_new = esfs_pkg::KIND_FOLDED;
		end else begin
			kind_new = esfs_pkg::KIND_NONE;
		end
	end

	assign push = in_acc & in_ch.is_final;
	assign pop  = out_valid_q & out_ch.ready;

	// Output register backed by a skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_kind_q   <= esfs_pkg::KIND_NONE;
			skid_kind_q  <= esfs_pkg::KIND_NONE;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_kind_q   <= skid_kind_q;
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				out_kind_q  <= kind_new;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end else if (push) begin
			skid_kind_q  <= kind_new;
			skid_valid_q <= 1'b1;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.match_kind = out_kind_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while output register is empty");

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.is_final) |=> out_valid_q)
		else $error("final request produced no result");

	a_exact_within_folded: assert property (@(posedge clk) disable iff (!arst_n)
		(exact_vec & ~folded_vec) == '0)
		else $error("exact progress bit set without folded progress bit");

	a_seen_exact_implies_folded: assert property (@(posedge clk) disable iff (!arst_n)
		seen_exact_q |-> seen_folded_q)
		else $error("exact hit recorded without folded hit");

endmodule
